// File: rtl/imu_liftoff_detector_defines.svh
// Assertion macros used by the liftoff detector checker.
`ifndef IMU_LIFTOFF_DETECTOR_DEFINES_SVH
`define IMU_LIFTOFF_DETECTOR_DEFINES_SVH

// Condition in one cycle implies a condition in the next, outside reset.
`define ILD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("liftoff detector check failed");

// Condition implies a condition in the same cycle, outside reset.
`define ILD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("liftoff detector check failed");

// Condition that must hold at the edge after any edge that sees reset applied.
`define ILD_ASSERT_IN_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk_i) (!rst_ni) |=> (cons)) \
    else $error("liftoff detector reset check failed");

`endif

// File: rtl/ild_pkg.sv
// Shared types and constants of the liftoff detector.
`timescale 1ns / 1ps
package ild_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_RUN   = 2'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 32'd16777216; // 4 g squared
  localparam logic [RUN_W-1:0] REQ_RUN_RST   = 8'd50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] z;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] x;
    logic                       ok;
  } sample_t;

  // Per-stage tag that travels with each word down the pipeline
  typedef struct packed {
    logic occ;     // stage holds a word
    logic ok;      // sample flagged good
    logic tested;  // window full after this sample: magnitude test applies
  } stage_t;

endpackage

// File: rtl/ild_window.sv
// Ring window memory of the last samples and the running per-axis sums.
`timescale 1ns / 1ps
module ild_window #(
  parameter int unsigned WINDOW_LEN = 16,
  parameter int unsigned SUM_W      = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,   // take a new word into the read stage
  input  ild_pkg::sample_t        smp_i,
  input  logic                    adv_i,   // read stage word moves on
  output ild_pkg::stage_t         s1_o,
  output logic signed [SUM_W-1:0] sum_x_o,
  output logic signed [SUM_W-1:0] sum_y_o,
  output logic signed [SUM_W-1:0] sum_z_o
);

  localparam int unsigned PTR_W  = $clog2(WINDOW_LEN);
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned ENT_W  = 3 * ild_pkg::SAMPLE_W;
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_LEN - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);

  logic [ENT_W-1:0] win_mem [WINDOW_LEN];

  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  ild_pkg::stage_t   s1_q, s1_d;
  logic              full_q;       // oldest entry leaves the window
  logic [PTR_W-1:0]  ptr_q;
  ild_pkg::sample_t  smp_q;
  logic [ENT_W-1:0]  rd_q;

  logic signed [SUM_W-1:0] sx_q, sy_q, sz_q;
  logic signed [SUM_W-1:0] sx_d, sy_d, sz_d;
  logic signed [ild_pkg::SAMPLE_W-1:0] old_x, old_y, old_z;
  logic write_en;

  assign write_en = adv_i && s1_q.occ && smp_q.ok;

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    s1_d   = s1_q;
    if (adv_i) begin
      s1_d.occ = 1'b0;
    end
    if (acc_i) begin
      s1_d.occ    = 1'b1;
      s1_d.ok     = smp_i.ok;
      s1_d.tested = smp_i.ok && (fill_q >= FILL_LAST);
      if (smp_i.ok) begin
        wp_d = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
        if (fill_q != FILL_FULL) begin
          fill_d = fill_q + 1'b1;
        end
      end
    end
  end

  // Drop the oldest sample once the window is full, add the new one
  always_comb begin
    old_x = rd_q[ild_pkg::SAMPLE_W-1:0];
    old_y = rd_q[2*ild_pkg::SAMPLE_W-1:ild_pkg::SAMPLE_W];
    old_z = rd_q[3*ild_pkg::SAMPLE_W-1:2*ild_pkg::SAMPLE_W];
    sx_d  = sx_q + SUM_W'(smp_q.x);
    sy_d  = sy_q + SUM_W'(smp_q.y);
    sz_d  = sz_q + SUM_W'(smp_q.z);
    if (full_q) begin
      sx_d = sx_d - SUM_W'(old_x);
      sy_d = sy_d - SUM_W'(old_y);
      sz_d = sz_d - SUM_W'(old_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      s1_q   <= '0;
      sx_q   <= '0;
      sy_q   <= '0;
      sz_q   <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      s1_q   <= s1_d;
      if (write_en) begin
        sx_q <= sx_d;
        sy_q <= sy_d;
        sz_q <= sz_d;
      end
    end
  end

  // Read slot is never the slot being written: the pointer has moved past it
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q   <= win_mem[wp_q];
      smp_q  <= smp_i;
      ptr_q  <= wp_q;
      full_q <= (fill_q == FILL_FULL);
    end
    if (write_en) begin
      win_mem[ptr_q] <= {smp_q.z, smp_q.y, smp_q.x};
    end
  end

  assign s1_o    = s1_q;
  assign sum_x_o = sx_q;
  assign sum_y_o = sy_q;
  assign sum_z_o = sz_q;

endmodule

// File: rtl/imu_liftoff_detector.sv
// Liftoff detector: top level with magnitude test, run counter and output word.
`timescale 1ns / 1ps
// Usage
//   Input stream: one word per accelerometer sample. tdata carries x, y, z
//   (signed, 1/2048 g), tuser the sample-good flag. A bad sample clears the
//   run counter and leaves the window untouched.
//   Output stream: one word per input word; bit 0 of tdata is liftoff.
//   Config port: write threshold (index 0) or required run (index 1) while idle.
// Pipeline and throughput
//   An accepted word passes these stages before the output register offers it:
//   read of the oldest window slot, running-sum update and squares, then add,
//   compare and run count. One word per cycle sustained while the output word
//   is taken; the window memory is read once and written once per cycle, at
//   different slots.
// Reset
//   Clears sums, write pointer, fill count, run count and all stage flags; the
//   registers return to 4 g squared and 50. The window memory is not cleared:
//   a slot's old contents are used only after the window has filled.
// Backpressure
//   While the output word is not taken, words keep moving into empty stages;
//   input ready drops only once every stage and the output register are full.
module imu_liftoff_detector #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // accel_x, accel_y, accel_z
  input  logic                           s_axis_tuser,  // sample_valid
  // Output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // liftoff, zero pad
  // Configuration
  input  logic                           cfg_we_i,
  input  logic [ild_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ild_pkg::THR_W-1:0]      cfg_data_i
);

  localparam int unsigned SUM_W  = ild_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int unsigned SQ_W   = 2 * SUM_W;
  localparam int unsigned MAG_W  = SQ_W + 2;
  localparam int unsigned NSQ_W  = $clog2(WINDOW_LEN * WINDOW_LEN + 1);
  localparam int unsigned LIM_W  = ild_pkg::THR_W + NSQ_W;
  localparam int unsigned CMP_W  = (MAG_W > LIM_W) ? MAG_W : LIM_W;
  localparam logic [NSQ_W-1:0] WIN_SQ = NSQ_W'(WINDOW_LEN * WINDOW_LEN);

  // Config registers
  logic [ild_pkg::THR_W-1:0] thr_q;
  logic [ild_pkg::RUN_W-1:0] req_q;
  logic [LIM_W-1:0]          lim_q;

  // Pipeline control
  ild_pkg::stage_t s1, s2_q, s3_q;
  logic out_free, rdy3, rdy2, rdy1;
  logic acc, adv12, adv23, adv3o;

  ild_pkg::sample_t smp;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [SQ_W-1:0]  sqx, sqy, sqz;
  logic [SQ_W-1:0]         sqx_q, sqy_q, sqz_q;
  logic [MAG_W-1:0]        mag;
  logic                    pass;

  logic [ild_pkg::RUN_W-1:0] run_q, run_d;
  logic [ild_pkg::RUN_W:0]   run_inc;
  logic                      ov_q, liftoff_q, liftoff_d;

  // Each stage takes a word when empty or when its word moves on
  assign out_free = !ov_q || m_axis_tready;
  assign rdy3     = !s3_q.occ || out_free;
  assign rdy2     = !s2_q.occ || rdy3;
  assign rdy1     = !s1.occ || rdy2;
  assign acc      = s_axis_tvalid && rdy1;
  assign adv12    = s1.occ && rdy2;
  assign adv23    = s2_q.occ && rdy3;
  assign adv3o    = s3_q.occ && out_free;

  assign s_axis_tready = rdy1;

  assign smp.x  = s_axis_tdata[15:0];
  assign smp.y  = s_axis_tdata[31:16];
  assign smp.z  = s_axis_tdata[47:32];
  assign smp.ok = s_axis_tuser;

  ild_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .smp_i   (smp),
    .adv_i   (adv12),
    .s1_o    (s1),
    .sum_x_o (sum_x),
    .sum_y_o (sum_y),
    .sum_z_o (sum_z)
  );

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ild_pkg::THRESHOLD_RST;
      req_q <= ild_pkg::REQ_RUN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ild_pkg::REG_THRESHOLD: thr_q <= cfg_data_i;
        ild_pkg::REG_REQ_RUN:   req_q <= cfg_data_i[ild_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Scale threshold by the window length squared so the test needs no divide
  always_ff @(posedge clk_i) begin
    lim_q <= LIM_W'(thr_q) * LIM_W'(WIN_SQ);
  end

  // Squares of the sums the stage-2 word left in the sum registers
  assign sqx = sum_x * sum_x;
  assign sqy = sum_y * sum_y;
  assign sqz = sum_z * sum_z;

  always_ff @(posedge clk_i) begin
    if (adv23) begin
      sqx_q <= sqx;
      sqy_q <= sqy;
      sqz_q <= sqz;
    end
  end

  assign mag  = MAG_W'(sqx_q) + MAG_W'(sqy_q) + MAG_W'(sqz_q);
  assign pass = CMP_W'(mag) > CMP_W'(lim_q);

  // Run counter: saturate at the required run, clear on fail or bad sample
  always_comb begin
    run_inc   = {1'b0, run_q} + 1'b1;
    run_d     = run_q;
    liftoff_d = 1'b0;
    if (!s3_q.ok) begin
      run_d = '0;
    end else if (s3_q.tested) begin
      if (!pass) begin
        run_d = '0;
      end else if (run_inc < {1'b0, req_q}) begin
        run_d = run_inc[ild_pkg::RUN_W-1:0];
      end else begin
        run_d = req_q;
      end
      liftoff_d = (run_d >= req_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q  <= '0;
      s3_q  <= '0;
      run_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (adv12) begin
        s2_q <= s1;
      end else if (adv23) begin
        s2_q.occ <= 1'b0;
      end
      if (adv23) begin
        s3_q <= s2_q;
      end else if (adv3o) begin
        s3_q.occ <= 1'b0;
      end
      if (adv3o) begin
        run_q <= run_d;
        ov_q  <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3o) begin
      liftoff_q <= liftoff_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, liftoff_q};

endmodule

// File: rtl/ild_checker.sv
// Port-level checks of the liftoff detector and their bind.
`timescale 1ns / 1ps
`include "imu_liftoff_detector_defines.svh"
module ild_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Hold a stalled output word
  `ILD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ILD_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // Input stalls only behind a stalled output word
  `ILD_ASSERT_NOW(a_ready_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // Pad bits of the result word stay zero
  `ILD_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)
  // No output word during reset
  `ILD_ASSERT_IN_RESET(a_rst_idle, !m_axis_tvalid)

endmodule

bind imu_liftoff_detector ild_checker u_ild_checker (.*);
